>>> rtl/core/kwmh_pkg.sv
package kwmh_pkg;

  localparam int MAX_RUNS  = 16;
  localparam int KEY_BYTES = 8;

  localparam int KEY_W = 64;
  localparam int RUN_W = 4;
  localparam int STS_W = 2;
  localparam int IDX_W = $clog2(MAX_RUNS);
  localparam int CNT_W = $clog2(MAX_RUNS + 1);

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [RUN_W-1:0] run_index;
    logic [KEY_W-1:0] record_key;
  } in_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] popped_key;
    logic [RUN_W-1:0] popped_run;
    logic [STS_W-1:0] status;
    logic [CNT_W-1:0] occupancy;
  } out_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [RUN_W-1:0] run;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_FIN
  } state_t;

endpackage

>>> rtl/core/kwmh_ram.sv
module kwmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/kway_merge_min_heap.sv
// Binary min-heap of up to MAX_RUNS records for a k-way merge, ordered by key and then by
// run index. Each request is an insert or a pop and yields exactly one result carrying the
// status and the occupancy after the operation. The heap lives in a memory with one write
// and one registered read port, and a single key comparator walks it one level at a time:
// an insert sifts the new record up from the last slot, and a pop moves the last record to
// the root and sifts it down. A pop on an empty heap or an insert into a full heap goes
// straight to the result without writing the memory.
// The input is stalled while a request is in progress; a finished result waits in the output
// register, and the next request may be taken meanwhile.
module kway_merge_min_heap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kwmh_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kwmh_pkg::out_req_t out_data
);

  import kwmh_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  entry_t           cur_r, cur_nxt;
  entry_t           best_r, best_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] bidx_r, bidx_nxt;
  logic             bchild_r, bchild_nxt;
  out_req_t         res_r, res_nxt;
  out_req_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  entry_t           cmp_a, cmp_b;
  logic             cmp_lt;
  logic [IDX_W+1:0] left_w, right_w, cnt_ext;
  logic [IDX_W-1:0] idx_m1, pidx;
  logic             right_win;

  kwmh_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_RUNS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The one comparator: true when entry a leaves the heap before entry b.
  assign cmp_lt = (cmp_a.key < cmp_b.key) ||
                  ((cmp_a.key == cmp_b.key) && (cmp_a.run < cmp_b.run));

  assign left_w  = {1'b0, idx_r, 1'b1};
  assign right_w = left_w + (IDX_W+2)'(1);
  assign cnt_ext = (IDX_W+2)'(cnt_r);
  assign idx_m1  = idx_r - IDX_W'(1);
  assign pidx    = idx_m1 >> 1;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    idx_nxt       = idx_r;
    bidx_nxt      = bidx_r;
    bchild_nxt    = bchild_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = cur_r;
    ram_raddr     = '0;
    cmp_a         = ram_rdata;
    cmp_b         = cur_r;
    right_win     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          if (in_data.operation == OP_INSERT) begin
            if (cnt_r >= CNT_W'(MAX_RUNS)) begin
              res_nxt.status    = STS_FULL;
              res_nxt.occupancy = cnt_r;
              state_nxt         = ST_FIN;
            end else begin
              cur_nxt.key       = in_data.record_key & KEY_MASK;
              cur_nxt.run       = in_data.run_index;
              idx_nxt           = cnt_r[IDX_W-1:0];
              cnt_nxt           = cnt_r + CNT_W'(1);
              res_nxt.status    = STS_OK;
              res_nxt.occupancy = cnt_r + CNT_W'(1);
              state_nxt         = ST_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_nxt.status    = STS_EMPTY;
              res_nxt.occupancy = '0;
              state_nxt         = ST_FIN;
            end else begin
              cnt_nxt           = cnt_r - CNT_W'(1);
              res_nxt.status    = STS_OK;
              res_nxt.occupancy = cnt_r - CNT_W'(1);
              ram_raddr         = '0;
              state_nxt         = ST_POP_ROOT;
            end
          end
        end
      end
      ST_POP_ROOT: begin
        res_nxt.popped_key = ram_rdata.key;
        res_nxt.popped_run = ram_rdata.run;
        ram_raddr          = cnt_r[IDX_W-1:0];
        state_nxt          = (cnt_r == '0) ? ST_FIN : ST_POP_LAST;
      end
      ST_POP_LAST: begin
        cur_nxt   = ram_rdata;
        idx_nxt   = '0;
        state_nxt = ST_DN_RDL;
      end
      ST_DN_RDL: begin
        if (left_w >= cnt_ext) begin
          ram_we    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          ram_raddr = left_w[IDX_W-1:0];
          state_nxt = ST_DN_RDR;
        end
      end
      ST_DN_RDR: begin
        cmp_a = ram_rdata;
        cmp_b = cur_r;
        if (cmp_lt) begin
          best_nxt   = ram_rdata;
          bidx_nxt   = left_w[IDX_W-1:0];
          bchild_nxt = 1'b1;
        end else begin
          best_nxt   = cur_r;
          bchild_nxt = 1'b0;
        end
        ram_raddr = right_w[IDX_W-1:0];
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmp_a     = ram_rdata;
        cmp_b     = best_r;
        right_win = (right_w < cnt_ext) && cmp_lt;
        ram_we    = 1'b1;
        if (!right_win && !bchild_r) begin
          state_nxt = ST_FIN;
        end else begin
          ram_wdata = right_win ? ram_rdata : best_r;
          idx_nxt   = right_win ? right_w[IDX_W-1:0] : bidx_r;
          state_nxt = ST_DN_RDL;
        end
      end
      ST_UP_RD: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          ram_raddr = pidx;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        cmp_a  = cur_r;
        cmp_b  = ram_rdata;
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = ram_rdata;
          idx_nxt   = pidx;
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    best_r   <= best_nxt;
    idx_r    <= idx_nxt;
    bidx_r   <= bidx_nxt;
    bchild_r <= bchild_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import kwmh_pkg::*;

  localparam int TOTAL_REQUESTS = 1400;
  localparam int MAX_REPORTS    = 200;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;

  kway_merge_min_heap u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [KEY_W-1:0] heap_key [MAX_RUNS];
  logic [RUN_W-1:0] heap_run [MAX_RUNS];
  int heap_cnt = 0;

  out_req_t pending_results [$];
  out_req_t last_result;

  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int inserts_sent = 0;
  int pops_sent = 0;
  int full_drops = 0;
  int empty_pops = 0;
  int rx_hold = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;

  function automatic bit leaves_first(int a, int b);
    if (heap_key[a] != heap_key[b]) return heap_key[a] < heap_key[b];
    return heap_run[a] < heap_run[b];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [KEY_W-1:0] k;
    logic [RUN_W-1:0] r;
    k = heap_key[a];
    r = heap_run[a];
    heap_key[a] = heap_key[b];
    heap_run[a] = heap_run[b];
    heap_key[b] = k;
    heap_run[b] = r;
  endfunction

  // Applies one request to the predicted heap and returns the result it must produce.
  function automatic out_req_t heap_apply(in_req_t req);
    out_req_t res;
    int i;
    int p;
    int best;
    res = '0;
    if (req.operation == OP_INSERT) begin
      if (heap_cnt >= MAX_RUNS) begin
        res.status = STS_FULL;
      end else begin
        i = heap_cnt;
        heap_key[i] = req.record_key & KEY_MASK;
        heap_run[i] = req.run_index;
        heap_cnt++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!leaves_first(i, p)) break;
          swap_entries(i, p);
          i = p;
        end
      end
    end else if (heap_cnt == 0) begin
      res.status = STS_EMPTY;
    end else begin
      res.popped_key = heap_key[0];
      res.popped_run = heap_run[0];
      heap_cnt--;
      heap_key[0] = heap_key[heap_cnt];
      heap_run[0] = heap_run[heap_cnt];
      i = 0;
      forever begin
        best = i;
        if (2 * i + 1 < heap_cnt && leaves_first(2 * i + 1, best)) best = 2 * i + 1;
        if (2 * i + 2 < heap_cnt && leaves_first(2 * i + 2, best)) best = 2 * i + 2;
        if (best == i) break;
        swap_entries(i, best);
        i = best;
      end
    end
    res.occupancy = CNT_W'(heap_cnt);
    return res;
  endfunction

  function automatic in_req_t make_req(logic op, logic [RUN_W-1:0] run,
                                       logic [KEY_W-1:0] key);
    in_req_t req;
    req.operation  = op;
    req.run_index  = run;
    req.record_key = key;
    return req;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  task automatic send_req(input in_req_t req);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    last_result = heap_apply(req);
    pending_results = {pending_results, last_result};
    requests_sent++;
    if (req.operation == OP_INSERT) inserts_sent++;
    else pops_sent++;
    if (last_result.status == STS_FULL) full_drops++;
    if (last_result.status == STS_EMPTY) empty_pops++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pop_any();
    send_req(make_req(OP_POP, RUN_W'($urandom), random_key()));
  endtask

  task automatic test_empty_pop();
    send_req(make_req(OP_POP, 4'hF, '1));
  endtask

  task automatic test_fill_and_overflow();
    logic [KEY_W-1:0] keys [16] = '{
      64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0,
      64'h0, 64'h8000_0000_0000_0000, 64'h1, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00,
      64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF};
    logic [RUN_W-1:0] runs [16] = '{
      4'd3, 4'd15, 4'd0, 4'd15, 4'd7, 4'd8, 4'd1, 4'd10,
      4'd5, 4'd2, 4'd2, 4'd0, 4'd12, 4'd4, 4'd9, 4'd6};
    for (int i = 0; i < 16; i++) send_req(make_req(OP_INSERT, runs[i], keys[i]));
    send_req(make_req(OP_INSERT, 4'h0, 64'h0));
    repeat (6) pop_any();
  endtask

  // The receiver holds off while requests keep coming, so the block backs up.
  task automatic test_output_hold();
    rx_hold = 300;
    tx_gaps_on = 1'b0;
    repeat (12) begin
      send_req(make_req($urandom_range(0, 3) == 0 ? OP_POP : OP_INSERT,
                        RUN_W'($urandom), random_key()));
    end
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  // A merge of sorted runs: fill with one head per run, then for 10 to 60 steps pop and
  // mostly refill from the popped run with a key no smaller than the last one, then drain.
  task automatic merge_sequence();
    logic [KEY_W-1:0] tail [MAX_RUNS];
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] nxt;
    logic [RUN_W-1:0] run;
    int runs;
    int offset;
    int steps;
    bit narrow;
    while (heap_cnt > 0) pop_any();
    runs   = $urandom_range(2, MAX_RUNS);
    offset = $urandom_range(0, MAX_RUNS - 1);
    narrow = ($urandom_range(0, 2) == 0);
    base   = random_key();
    for (int r = 0; r < runs; r++) begin
      run = RUN_W'(r + offset);
      tail[run] = narrow ? base + $urandom_range(0, 3) : random_key();
      send_req(make_req(OP_INSERT, run, tail[run]));
    end
    steps = $urandom_range(10, 60);
    for (int s = 0; s < steps && heap_cnt > 0; s++) begin
      pop_any();
      run = last_result.popped_run;
      if ($urandom_range(0, 5) != 0) begin
        nxt = tail[run] + (narrow ? $urandom_range(0, 2) : $urandom_range(0, 1 << 20));
        tail[run] = (nxt < tail[run]) ? '1 : nxt;
        send_req(make_req(OP_INSERT, run, tail[run]));
      end
    end
    while (heap_cnt > 0) pop_any();
    if ($urandom_range(0, 2) == 0) pop_any();
  endtask

  task automatic noise_burst();
    int n;
    int insert_weight;
    n = $urandom_range(5, 40);
    insert_weight = $urandom_range(2, 8);
    repeat (n) begin
      send_req(make_req($urandom_range(0, 9) < insert_weight ? OP_INSERT : OP_POP,
                        RUN_W'($urandom), random_key()));
    end
  endtask

  task automatic test_random_mix();
    while (requests_sent < TOTAL_REQUESTS) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) merge_sequence();
      else noise_burst();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    int stall_left;
    int wait_n;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        wait_n = rx_gaps_on ? $urandom_range(0, 12) : 0;
        stall_left = wait_n;
        out_stall <= (wait_n != 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= (stall_left != 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
      end else begin
        out_req_t want;
        want = pending_results.pop_front();
        check_field("popped_key", want.popped_key, out_data.popped_key);
        check_field("popped_run", KEY_W'(want.popped_run), KEY_W'(out_data.popped_run));
        check_field("status", KEY_W'(want.status), KEY_W'(out_data.status));
        check_field("occupancy", KEY_W'(want.occupancy), KEY_W'(out_data.occupancy));
        results_checked++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pop();
    test_fill_and_overflow();
    wait_drained();
    test_output_hold();
    test_random_mix();
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests: %0d inserts with %0d dropped on a full heap,",
             requests_sent, inserts_sent, full_drops);
    $display("%0d pops with %0d on an empty heap; checked %0d results in heap order.",
             pops_sent, empty_pops, results_checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
